// ===== src/efold_pkg.sv =====
package efold_pkg;

    localparam int FP_W    = 32;
    localparam int MODE_W  = 3;
    localparam int EXP_W   = 11;
    localparam int WORK_W  = 50;
    localparam int DIV_BITS = 26;
    localparam int CNT_W   = $clog2(DIV_BITS);

    localparam logic [MODE_W-1:0] MODE_ADD = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MAX = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SUB = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV = 3'd4;

    localparam logic [FP_W-1:0] DEFAULT_NAN = 32'h7FC0_0000;
    localparam logic [FP_W-2:0] INF_MAG     = 31'h7F80_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_PRE,
        ST_DIV,
        ST_NORM,
        ST_DONE
    } efold_state_t;

    // One fold request: accumulator op operand.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [FP_W-1:0]   a;
        logic [FP_W-1:0]   b;
    } efold_req_t;

endpackage

// ===== src/efold_fpu.sv =====
module efold_fpu
    import efold_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  efold_req_t      req,
    output logic            done,
    output logic [FP_W-1:0] result
);

    function automatic logic fp_is_nan(input logic [FP_W-1:0] x);
        return x[30:0] > INF_MAG;
    endfunction

    function automatic logic [FP_W-1:0] fp_pick_nan(input logic [FP_W-1:0] x,
                                                   input logic [FP_W-1:0] y);
        logic [FP_W-1:0] r;
        if (fp_is_nan(x) && !x[22])
            r = x | 32'h0040_0000;
        else if (fp_is_nan(y) && !y[22])
            r = y | 32'h0040_0000;
        else if (fp_is_nan(x))
            r = x;
        else
            r = y;
        return r;
    endfunction

    // Monotonic key: unsigned order of keys follows numeric order.
    function automatic logic [FP_W-1:0] fp_key(input logic [FP_W-1:0] x);
        return x[31] ? ~x : (x | 32'h8000_0000);
    endfunction

    efold_state_t st_reg, st_next;

    logic                    sa_reg, sa_next, sb_reg, sb_next, sgn_reg, sgn_next;
    logic [23:0]             ma_reg, ma_next, mb_reg, mb_next;
    logic signed [EXP_W-1:0] ea_reg, ea_next, eb_reg, eb_next, ex_reg, ex_next;
    logic [WORK_W-1:0]       r_reg, r_next;
    logic [24:0]             rem_reg, rem_next;
    logic [DIV_BITS-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [FP_W-1:0]         res_reg, res_next;

    // Unpacked request operands.
    logic                    a_zero, b_zero, a_inf, b_inf, sb_eff, sx;
    logic [23:0]             ma_in, mb_in;
    logic signed [EXP_W-1:0] ea_in, eb_in;
    logic                    spec_hit;
    logic [FP_W-1:0]         spec_val;

    assign ma_in  = {req.a[30:23] != 8'd0, req.a[22:0]};
    assign mb_in  = {req.b[30:23] != 8'd0, req.b[22:0]};
    assign ea_in  = (req.a[30:23] == 8'd0) ? EXP_W'(1) : $signed({3'b000, req.a[30:23]});
    assign eb_in  = (req.b[30:23] == 8'd0) ? EXP_W'(1) : $signed({3'b000, req.b[30:23]});
    assign a_zero = req.a[30:0] == 31'd0;
    assign b_zero = req.b[30:0] == 31'd0;
    assign a_inf  = req.a[30:0] == INF_MAG;
    assign b_inf  = req.b[30:0] == INF_MAG;
    assign sb_eff = req.b[31] ^ (req.mode == MODE_SUB);
    assign sx     = req.a[31] ^ req.b[31];

    // Results that need no arithmetic: NaN, infinity, max, divide by zero, zero quotients, unknown modes.
    always_comb
    begin
        spec_hit = 1'b1;
        spec_val = req.a;
        case (req.mode)
            MODE_MAX:
            begin
                if (fp_is_nan(req.a) || fp_is_nan(req.b))
                    spec_val = fp_pick_nan(req.a, req.b);
                else if ((req.a[30:0] | req.b[30:0]) == 31'd0)
                    spec_val = req.a & req.b;
                else
                    spec_val = (fp_key(req.a) > fp_key(req.b)) ? req.a : req.b;
            end
            MODE_ADD, MODE_SUB:
            begin
                if (fp_is_nan(req.a) || fp_is_nan(req.b))
                    spec_val = fp_pick_nan(req.a, req.b);
                else if (a_inf)
                    spec_val = (b_inf && (req.a[31] != sb_eff)) ? DEFAULT_NAN : req.a;
                else if (b_inf)
                    spec_val = {sb_eff, INF_MAG};
                else
                    spec_hit = 1'b0;
            end
            MODE_MUL:
            begin
                if (fp_is_nan(req.a) || fp_is_nan(req.b))
                    spec_val = fp_pick_nan(req.a, req.b);
                else if (a_inf || b_inf)
                    spec_val = (a_zero || b_zero) ? DEFAULT_NAN : {sx, INF_MAG};
                else
                    spec_hit = 1'b0;
            end
            MODE_DIV:
            begin
                if (fp_is_nan(req.a) || fp_is_nan(req.b))
                    spec_val = fp_pick_nan(req.a, req.b);
                else if (b_zero)
                    spec_val = a_zero ? DEFAULT_NAN : {sx, INF_MAG};
                else if (a_inf)
                    spec_val = b_inf ? DEFAULT_NAN : {sx, INF_MAG};
                else if (b_inf || a_zero)
                    spec_val = {sx, 31'd0};
                else
                    spec_hit = 1'b0;
            end
            default:
                spec_val = req.a;
        endcase
    end

    // Alignment and add for sum and subtract.
    logic                    a_big;
    logic signed [EXP_W-1:0] e_big, e_sml, dexp;
    logic [23:0]             m_big, m_sml;
    logic [WORK_W-1:0]       w_big, w_sml, w_al, add_sum;
    logic [5:0]              al_sh;

    always_comb
    begin
        a_big = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
        e_big = a_big ? ea_reg : eb_reg;
        e_sml = a_big ? eb_reg : ea_reg;
        m_big = a_big ? ma_reg : mb_reg;
        m_sml = a_big ? mb_reg : ma_reg;
        dexp  = e_big - e_sml;
        al_sh = dexp[5:0];
        w_big = {1'b0, m_big, 25'd0};
        w_sml = {1'b0, m_sml, 25'd0};
        if (dexp >= EXP_W'(WORK_W))
            w_al = {{(WORK_W-1){1'b0}}, |m_sml};
        else
            w_al = (w_sml >> al_sh)
                 | {{(WORK_W-1){1'b0}}, |(w_sml & ~({WORK_W{1'b1}} << al_sh))};
        add_sum = (sa_reg == sb_reg) ? (w_big + w_al) : (w_big - w_al);
    end

    // Mantissa multiplier.
    logic [47:0] prod;
    assign prod = ma_reg * mb_reg;

    // One restoring divide step.
    logic        div_ge;
    logic [24:0] rem_sub;
    assign div_ge  = rem_reg >= {1'b0, mb_reg};
    assign rem_sub = div_ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;

    // Normalize and round.
    logic                    n_zero, n_right, n_left, n_denorm, n_fin, rnd_inc;
    logic signed [EXP_W-1:0] dn_amt, ex_r;
    logic [WORK_W-1:0]       dn_val;
    logic [24:0]             m25;
    logic [23:0]             mant;
    logic [FP_W-1:0]         rnd_val;

    always_comb
    begin
        n_zero   = r_reg == '0;
        n_right  = r_reg[WORK_W-1];
        n_left   = !r_reg[WORK_W-2] && (ex_reg > EXP_W'(1));
        n_denorm = ex_reg < EXP_W'(1);
        n_fin    = n_zero || !(n_right || n_left || n_denorm);
        dn_amt   = EXP_W'(1) - ex_reg;
        if (dn_amt >= EXP_W'(WORK_W))
            dn_val = {{(WORK_W-1){1'b0}}, 1'b1};
        else
            dn_val = (r_reg >> dn_amt[5:0])
                   | {{(WORK_W-1){1'b0}},
                      |(r_reg & ~({WORK_W{1'b1}} << dn_amt[5:0]))};
        rnd_inc = r_reg[24] & (r_reg[25] | (|r_reg[23:0]));
        m25     = {1'b0, r_reg[48:25]} + {24'd0, rnd_inc};
        ex_r    = m25[24] ? (ex_reg + EXP_W'(1)) : ex_reg;
        mant    = m25[24] ? 24'h80_0000 : m25[23:0];
        if (ex_r >= EXP_W'(255))
            rnd_val = {sgn_reg, INF_MAG};
        else
            rnd_val = {sgn_reg, (mant[23] ? ex_r[7:0] : 8'd0), mant[22:0]};
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
                if (start)
                begin
                    if (spec_hit)
                        st_next = ST_DONE;
                    else if (req.mode == MODE_MUL)
                        st_next = ST_MUL;
                    else if (req.mode == MODE_DIV)
                        st_next = ST_PRE;
                    else
                        st_next = ST_ADD;
                end
            ST_ADD:  st_next = ST_NORM;
            ST_MUL:  st_next = ST_NORM;
            ST_PRE:  if (ma_reg[23] && mb_reg[23]) st_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CNT_W'(DIV_BITS - 1)) st_next = ST_NORM;
            ST_NORM: if (n_fin) st_next = ST_DONE;
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        done   = st_reg == ST_DONE;
        result = res_reg;
    end

    always_comb
    begin
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        sgn_next = sgn_reg;
        ma_next  = ma_reg;
        mb_next  = mb_reg;
        ea_next  = ea_reg;
        eb_next  = eb_reg;
        ex_next  = ex_reg;
        r_next   = r_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        cnt_next = cnt_reg;
        res_next = res_reg;
        case (st_reg)
            ST_IDLE:
                if (start)
                begin
                    sa_next  = req.a[31];
                    sb_next  = sb_eff;
                    sgn_next = sx;
                    ma_next  = ma_in;
                    mb_next  = mb_in;
                    ea_next  = ea_in;
                    eb_next  = eb_in;
                    res_next = spec_val;
                end
            ST_ADD:
            begin
                r_next   = add_sum;
                ex_next  = e_big;
                sgn_next = (add_sum == '0) ? (sa_reg & sb_reg) : (a_big ? sa_reg : sb_reg);
            end
            ST_MUL:
            begin
                r_next  = {prod, 2'b00};
                ex_next = ea_reg + eb_reg - EXP_W'(127);
            end
            ST_PRE:
            begin
                if (!ma_reg[23])
                begin
                    ma_next = {ma_reg[22:0], 1'b0};
                    ea_next = ea_reg - EXP_W'(1);
                end
                else if (!mb_reg[23])
                begin
                    mb_next = {mb_reg[22:0], 1'b0};
                    eb_next = eb_reg - EXP_W'(1);
                end
                else
                begin
                    rem_next = {1'b0, ma_reg};
                    q_next   = '0;
                    cnt_next = '0;
                    ex_next  = ea_reg - eb_reg + EXP_W'(127);
                end
            end
            ST_DIV:
            begin
                rem_next = {rem_sub[23:0], 1'b0};
                q_next   = {q_reg[DIV_BITS-2:0], div_ge};
                cnt_next = cnt_reg + CNT_W'(1);
                r_next   = {1'b0, q_reg[DIV_BITS-2:0], div_ge, 22'd0, rem_sub != 25'd0};
            end
            ST_NORM:
            begin
                if (n_zero)
                    res_next = {sgn_reg, 31'd0};
                else if (n_right)
                begin
                    r_next  = {1'b0, r_reg[WORK_W-1:2], r_reg[1] | r_reg[0]};
                    ex_next = ex_reg + EXP_W'(1);
                end
                else if (n_left)
                begin
                    r_next  = {r_reg[WORK_W-2:0], 1'b0};
                    ex_next = ex_reg - EXP_W'(1);
                end
                else if (n_denorm)
                begin
                    r_next  = dn_val;
                    ex_next = EXP_W'(1);
                end
                else
                    res_next = rnd_val;
            end
            default:
                res_next = res_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
        sgn_reg <= sgn_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        ea_reg  <= ea_next;
        eb_reg  <= eb_next;
        ex_reg  <= ex_next;
        r_reg   <= r_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

endmodule

// ===== src/eltwise_fp32_fold.sv =====
// Channel   Direction  Signals                       Contents
// s_*       in         s_tvalid/s_tready/s_tdata     operand_bits; tuser first_operand;
//                      s_tlast, s_tuser              tlast last_operand
// m_*       out        m_tvalid/m_tready/m_tdata     result_bits
// cfg_*     in         cfg_wr_en/cfg_wr_data         operation_mode
//
// An operand flagged first loads the accumulator. A later operand goes through the
// shared floating-point unit: sum or subtract aligns and adds, product multiplies the
// mantissas, and both then normalize one shift at a time; divide first shifts each
// subnormal operand's mantissa left once per leading zero, then yields one quotient
// bit per cycle, then normalizes; max and special values need no arithmetic.
// A result flagged last moves to the output register once that register is free.
// Reset clears the accumulator to +0 and the mode to sum. A result waiting for a
// stalled output holds off new operands.
module eltwise_fp32_fold
    import efold_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [FP_W-1:0]   s_tdata,      // [31:0] operand_bits
    input  logic              s_tlast,      // last_operand
    input  logic              s_tuser,      // [0] first_operand
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [FP_W-1:0]   m_tdata,      // [31:0] result_bits
    input  logic              cfg_wr_en,
    input  logic [MODE_W-1:0] cfg_wr_data   // operation_mode
);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [FP_W-1:0]   acc_reg, acc_next;
    logic              busy_reg, busy_next;
    logic              last_reg, last_next;
    logic              pend_reg, pend_next;
    logic              mval_reg, mval_next;
    logic [FP_W-1:0]   mdat_reg, mdat_next;

    logic              accept, start, out_free, fpu_done;
    logic [FP_W-1:0]   fpu_res;
    efold_req_t        req;

    // A transfer is taken only while the fold unit is free and no result waits to leave.
    assign s_tready = !busy_reg && !pend_reg;
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && !s_tuser;
    assign out_free = !mval_reg || m_tready;

    assign req.mode = mode_reg;
    assign req.a    = acc_reg;
    assign req.b    = s_tdata;

    efold_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_comb
    begin
        mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;
        acc_next  = acc_reg;
        busy_next = busy_reg;
        last_next = last_reg;
        pend_next = pend_reg;
        mval_next = mval_reg;
        mdat_next = mdat_reg;

        if (accept)
        begin
            if (s_tuser)
            begin
                // A first operand loads the accumulator unchanged.
                acc_next  = s_tdata;
                pend_next = s_tlast;
            end
            else
            begin
                busy_next = 1'b1;
                last_next = s_tlast;
            end
        end

        if (fpu_done)
        begin
            acc_next  = fpu_res;
            busy_next = 1'b0;
            pend_next = last_reg;
        end

        // The output register takes the accumulator once its previous transfer is gone.
        if (pend_reg && out_free)
        begin
            mval_next = 1'b1;
            mdat_next = acc_reg;
            pend_next = 1'b0;
        end
        else if (m_tready)
            mval_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_ADD;
            acc_reg  <= '0;
            busy_reg <= 1'b0;
            last_reg <= 1'b0;
            pend_reg <= 1'b0;
            mval_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
            last_reg <= last_next;
            pend_reg <= pend_next;
            mval_reg <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdat_reg <= mdat_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat_reg;

endmodule
